/* hdl/rmsm_pkg.sv */
package rmsm_pkg;

  // Field widths
  localparam int TAXON_W  = 5;
  localparam int SAMPLE_W = 32;
  localparam int COUNT_W  = 16;
  localparam int SUM_W    = 64;

  // Stream payload widths (packed, padded to whole bytes)
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 96;

  // Divider: restoring division, DIV_BITS quotient bits per stage
  localparam int DIV_BITS   = 8;
  localparam int DIV_STAGES = SAMPLE_W / DIV_BITS;
  localparam int DIV_ACC_W  = COUNT_W + SAMPLE_W;

endpackage

/* hdl/rmsm_ram.sv */
module rmsm_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/rmsm_div_pipe.sv */
module rmsm_div_pipe import rmsm_pkg::*; #(
  parameter int TAG_W = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [SAMPLE_W-1:0]                 num_i,
  input  logic [COUNT_W-1:0]                  den_i,
  input  logic [TAG_W-1:0]                    tag_i,
  output logic                                valid_o,
  output logic [SAMPLE_W-1:0]                 quo_o,
  output logic [TAG_W-1:0]                    tag_o,
  output logic [DIV_STAGES-1:0]               stage_valid_o,
  output logic [DIV_STAGES-1:0][TAG_W-1:0]    stage_tag_o
);

  // One restoring step per bit: remainder in the upper bits, quotient shifts in below
  function automatic logic [DIV_ACC_W-1:0] div_chunk(input logic [DIV_ACC_W-1:0] acc,
                                                     input logic [COUNT_W-1:0]   den);
    logic [DIV_ACC_W-1:0] a;
    logic [COUNT_W:0]     hi;
    logic                 qb;
    a = acc;
    for (int b = 0; b < DIV_BITS; b++) begin
      hi = a[DIV_ACC_W-1 -: (COUNT_W + 1)];
      qb = (hi >= {1'b0, den});
      if (qb) begin
        hi = hi - {1'b0, den};
      end
      a = {hi[COUNT_W-1:0], a[SAMPLE_W-2:0], qb};
    end
    return a;
  endfunction

  logic [DIV_STAGES-1:0]                 v_q;
  logic [DIV_ACC_W-1:0]                  acc_q [DIV_STAGES];
  logic [COUNT_W-1:0]                    den_q [DIV_STAGES];
  logic [TAG_W-1:0]                      tag_q [DIV_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DIV_STAGES-2:0], valid_i};
    end
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DIV_ACC_W-1:0] acc_in;
    logic [COUNT_W-1:0]   den_in;
    logic [TAG_W-1:0]     tag_in;

    if (s == 0) begin : g_first
      assign acc_in = {{COUNT_W{1'b0}}, num_i};
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign acc_in = acc_q[s-1];
      assign den_in = den_q[s-1];
      assign tag_in = tag_q[s-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[s] <= div_chunk(acc_in, den_in);
        den_q[s] <= den_in;
        tag_q[s] <= tag_in;
      end
    end

    assign stage_tag_o[s] = tag_q[s];
  end

  assign stage_valid_o = v_q;
  assign valid_o       = v_q[DIV_STAGES-1];
  assign quo_o         = acc_q[DIV_STAGES-1][SAMPLE_W-1:0];
  assign tag_o         = tag_q[DIV_STAGES-1];

endmodule

/* hdl/running_mean_sumsq_matrix_unit.sv */
// Running mean and sum of squared deviations (Welford update) for a symmetric
// matrix of distance samples. Each request names an unordered taxon pair, a new
// Q16.16 sample and its sample count k; the block reads the element's stored mean
// and Q32.32 sum of squares, applies mean += trunc((sample - mean) / k) and
// sumsq += (sample - mean) * (sample - new mean), saturating, writes the element
// back and returns the new values. A request is taken every cycle as long as the
// output buffer has a free slot and the request does not touch an element still
// in flight: the pipe is 9 stages (store read, difference, four divider stages of
// 8 quotient bits, mean update, 32x32 product, accumulate and write-back), so a
// request hitting a busy element waits until that element has been written back.
// Results arrive through a two-entry output buffer. After reset the store is
// swept to zero, one entry a cycle, over all MAX_TAXA*MAX_TAXA entries (1024 by
// default); no request is taken during that sweep. Indices at or beyond MAX_TAXA
// wrap modulo MAX_TAXA; a count of zero is taken as one.
module running_mean_sumsq_matrix_unit import rmsm_pkg::*; #(
  parameter int MAX_TAXA = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // row[4:0], col[9:5], sample[41:10], count[57:42], zero pad[63:58]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // new_mean[31:0], new_sumsq[95:32]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // saturated[0]
  output logic                 m_axis_tuser
);

  localparam int DEPTH = MAX_TAXA * MAX_TAXA;
  localparam int AW    = $clog2(DEPTH);
  localparam int RAM_W = SAMPLE_W + SUM_W;
  localparam int TAG_W = AW + SAMPLE_W + SUM_W + 1 + SAMPLE_W;
  localparam int OB_W  = SAMPLE_W + SUM_W + 1;

  // Fold each index modulo MAX_TAXA, order the pair, and form min*MAX_TAXA + max
  function automatic logic [AW-1:0] pair_addr(input logic [TAXON_W-1:0] a,
                                              input logic [TAXON_W-1:0] b);
    logic [13:0] i;
    logic [13:0] j;
    logic [13:0] t;
    logic [13:0] lim;
    logic [16:0] full;
    i = 14'(a);
    j = 14'(b);
    for (int s = TAXON_W - 1; s >= 0; s--) begin
      lim = 14'(MAX_TAXA << s);
      if (i >= lim) begin
        i = i - lim;
      end
      if (j >= lim) begin
        j = j - lim;
      end
    end
    if (i > j) begin
      t = i;
      i = j;
      j = t;
    end
    full = 17'(i * MAX_TAXA) + 17'(j);
    return full[AW-1:0];
  endfunction

  // Output buffer and global advance
  logic [OB_W-1:0] ob_q [2];
  logic            ob_wr_q;
  logic            ob_rd_q;
  logic [1:0]      ob_cnt_q;
  logic            adv;
  logic            push;
  logic            pop;

  // Clearing sweep
  logic            clr_q;
  logic [AW-1:0]   clr_addr_q;

  // Stage registers
  logic                s1_v_q, s2_v_q, sm_v_q, sx_v_q, sa_v_q;
  logic [AW-1:0]       s1_addr_q, s2_addr_q, sm_addr_q, sx_addr_q, sa_addr_q;
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic [COUNT_W-1:0]  s1_k_q, s2_k_q;
  logic [SAMPLE_W-1:0] s2_mean_q, s2_magx_q;
  logic [SUM_W-1:0]    s2_sum_q;
  logic                s2_neg_q;
  logic [SAMPLE_W-1:0] sm_mean_q, sm_magx_q, sm_magy_q;
  logic [SUM_W-1:0]    sm_sum_q;
  logic [SAMPLE_W-1:0] sx_mean_q;
  logic [SUM_W-1:0]    sx_sum_q, sx_prod_q;
  logic [SAMPLE_W-1:0] sa_mean_q;
  logic [SUM_W-1:0]    sa_sum_q;
  logic                sa_sat_q;

  // Input side
  logic [AW-1:0]        in_addr;
  logic [COUNT_W-1:0]   in_k;
  logic                 hazard;
  logic                 accept;
  logic [RAM_W-1:0]     rdata;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [RAM_W-1:0]     ram_wdata;

  // Divider
  logic                           dv_valid;
  logic [SAMPLE_W-1:0]            dv_quo;
  logic [TAG_W-1:0]               dv_tag;
  logic [DIV_STAGES-1:0]          dv_stage_valid;
  logic [DIV_STAGES-1:0][TAG_W-1:0] dv_stage_tag;
  logic [AW-1:0]                  dv_addr;
  logic [SAMPLE_W-1:0]            dv_mean, dv_magx;
  logic [SUM_W-1:0]               dv_sum;
  logic                           dv_neg;

  logic [SUM_W:0]                 acc_sum;

  // The whole pipe moves while the output buffer has a free slot
  assign adv  = (ob_cnt_q != 2'd2);
  assign push = sa_v_q & adv;
  assign pop  = m_axis_tvalid & m_axis_tready;

  assign in_addr = pair_addr(s_axis_tdata[4:0], s_axis_tdata[9:5]);
  assign in_k    = (s_axis_tdata[57:42] == '0) ? COUNT_W'(1) : s_axis_tdata[57:42];

  // Hold a request whose element is still being updated further down the pipe
  always_comb begin
    hazard = (s1_v_q && s1_addr_q == in_addr) || (s2_v_q && s2_addr_q == in_addr) ||
             (sm_v_q && sm_addr_q == in_addr) || (sx_v_q && sx_addr_q == in_addr) ||
             (sa_v_q && sa_addr_q == in_addr);
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (dv_stage_valid[s] && dv_stage_tag[s][AW-1:0] == in_addr) begin
        hazard = 1'b1;
      end
    end
  end

  assign s_axis_tready = adv & ~clr_q & ~hazard;
  assign accept        = s_axis_tvalid & s_axis_tready;

  // Clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // Element store: mean in the low bits, sum of squares above
  assign ram_we    = clr_q | push;
  assign ram_waddr = clr_q ? clr_addr_q : sa_addr_q;
  assign ram_wdata = clr_q ? '0 : {sa_sum_q, sa_mean_q};

  rmsm_ram #(
    .WIDTH (RAM_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (adv),
    .raddr_i (in_addr),
    .rdata_o (rdata)
  );

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      sm_v_q <= 1'b0;
      sx_v_q <= 1'b0;
      sa_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
      sm_v_q <= dv_valid;
      sx_v_q <= sm_v_q;
      sa_v_q <= sx_v_q;
    end
  end

  assign {dv_magx, dv_neg, dv_sum, dv_mean, dv_addr} = dv_tag;
  assign acc_sum = {1'b0, sx_sum_q} + {1'b0, sx_prod_q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Stage 1: store read in flight
      s1_addr_q   <= in_addr;
      s1_sample_q <= s_axis_tdata[41:10];
      s1_k_q      <= in_k;
      // Stage 2: signed difference as sign and magnitude
      s2_addr_q   <= s1_addr_q;
      s2_k_q      <= s1_k_q;
      s2_mean_q   <= rdata[SAMPLE_W-1:0];
      s2_sum_q    <= rdata[RAM_W-1:SAMPLE_W];
      s2_neg_q    <= (s1_sample_q < rdata[SAMPLE_W-1:0]);
      s2_magx_q   <= (s1_sample_q < rdata[SAMPLE_W-1:0]) ?
                     (rdata[SAMPLE_W-1:0] - s1_sample_q) :
                     (s1_sample_q - rdata[SAMPLE_W-1:0]);
      // Mean update: quotient moves the mean toward the sample
      sm_addr_q   <= dv_addr;
      sm_sum_q    <= dv_sum;
      sm_magx_q   <= dv_magx;
      sm_magy_q   <= dv_magx - dv_quo;
      sm_mean_q   <= dv_neg ? (dv_mean - dv_quo) : (dv_mean + dv_quo);
      // Product of the two deviations
      sx_addr_q   <= sm_addr_q;
      sx_mean_q   <= sm_mean_q;
      sx_sum_q    <= sm_sum_q;
      sx_prod_q   <= sm_magx_q * sm_magy_q;
      // Accumulate, clip at the Q32.32 maximum
      sa_addr_q   <= sx_addr_q;
      sa_mean_q   <= sx_mean_q;
      sa_sat_q    <= acc_sum[SUM_W];
      sa_sum_q    <= acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
    end
  end

  rmsm_div_pipe #(
    .TAG_W (TAG_W)
  ) u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (adv),
    .valid_i       (s2_v_q),
    .num_i         (s2_magx_q),
    .den_i         (s2_k_q),
    .tag_i         ({s2_magx_q, s2_neg_q, s2_sum_q, s2_mean_q, s2_addr_q}),
    .valid_o       (dv_valid),
    .quo_o         (dv_quo),
    .tag_o         (dv_tag),
    .stage_valid_o (dv_stage_valid),
    .stage_tag_o   (dv_stage_tag)
  );

  // Two-entry output buffer: parts the pipe from the downstream stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_wr_q  <= 1'b0;
      ob_rd_q  <= 1'b0;
      ob_cnt_q <= 2'd0;
    end else begin
      if (push) begin
        ob_wr_q <= ~ob_wr_q;
      end
      if (pop) begin
        ob_rd_q <= ~ob_rd_q;
      end
      ob_cnt_q <= ob_cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ob_q[ob_wr_q] <= {sa_sat_q, sa_sum_q, sa_mean_q};
    end
  end

  assign m_axis_tvalid = (ob_cnt_q != 2'd0);
  assign m_axis_tdata  = ob_q[ob_rd_q][M_TDATA_W-1:0];
  assign m_axis_tuser  = ob_q[ob_rd_q][OB_W-1];

endmodule

/* dv/tb_top.sv */
module tb_top import rmsm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAXA = 32;
  localparam int DEPTH = TAXA * TAXA;

  // Idle phases: none, sender only, receiver only, both
  typedef enum logic [1:0] {PH_BUSY, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH} phase_e;

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [SAMPLE_W-1:0] sample;
    logic [TAXON_W-1:0]  col;
    logic [TAXON_W-1:0]  row;
  } request_t;

  typedef struct packed {
    logic              saturated;
    logic [SUM_W-1:0]  sumsq;
    logic [SAMPLE_W-1:0] mean;
  } update_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  running_mean_sumsq_matrix_unit #(.MAX_TAXA(TAXA)) DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Own copy of the element stores
  logic [SAMPLE_W-1:0] mean_mirror [DEPTH];
  logic [SUM_W-1:0]    sumsq_mirror [DEPTH];

  request_t pending_reqs[$];
  update_t  expected_updates[$];
  phase_e   phase = PH_BUSY;
  int       mismatches = 0;
  bit       stim_done = 1'b0;

  // Apply one Welford step to the mirror and return the update it produces
  function automatic update_t welford_update(request_t r);
    int unsigned a, b, idx;
    logic [SAMPLE_W-1:0] m, mx, mq, my;
    logic [COUNT_W-1:0]  k;
    logic [SUM_W-1:0]    s, prod;
    logic [SUM_W:0]      acc;
    logic                neg;
    update_t u;
    a = r.row % TAXA;
    b = r.col % TAXA;
    idx = (a < b) ? a * TAXA + b : b * TAXA + a;
    m = mean_mirror[idx];
    s = sumsq_mirror[idx];
    k = (r.count == '0) ? COUNT_W'(1) : r.count;
    neg = r.sample < m;
    mx = neg ? m - r.sample : r.sample - m;
    mq = mx / k;
    u.mean = neg ? m - mq : m + mq;
    my = mx - mq;
    prod = SUM_W'(mx) * SUM_W'(my);
    acc = {1'b0, s} + {1'b0, prod};
    u.saturated = acc[SUM_W];
    u.sumsq = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
    mean_mirror[idx] = u.mean;
    sumsq_mirror[idx] = u.sumsq;
    return u;
  endfunction

  function automatic bit idle_now(bit src);
    case (phase)
      PH_BUSY:      return 1'b0;
      PH_SRC_IDLE:  return src && ($urandom_range(99) < 56);
      PH_SNK_STALL: return !src && ($urandom_range(99) < 56);
      default:      return $urandom_range(99) < 12;
    endcase
  endfunction

  // Driver: present the head of the queue, hold it until taken, advance on acceptance
  always @(posedge clk_i) begin
    request_t r;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        r = pending_reqs.pop_front();
        expected_updates.insert(expected_updates.size(), welford_update(r));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() != 0 && !idle_now(1'b1)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= S_TDATA_W'(pending_reqs[0]);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= !idle_now(1'b0);
    end
  end

  // Monitor: compare each accepted update with the oldest expectation
  always @(posedge clk_i) begin
    update_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata};
      if (expected_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected update mean=%h sumsq=%h sat=%b",
                   got.mean, got.sumsq, got.saturated);
      end else begin
        want = expected_updates.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp mean=%h sumsq=%h sat=%b, got mean=%h sumsq=%h sat=%b",
                     want.mean, want.sumsq, want.saturated,
                     got.mean, got.sumsq, got.saturated);
        end
      end
    end
  end

  function automatic request_t make_req(int unsigned r, int unsigned c,
                                        logic [31:0] smp, logic [15:0] k);
    request_t q;
    q.row = TAXON_W'(r); q.col = TAXON_W'(c); q.sample = smp; q.count = k;
    return q;
  endfunction

  // Append one request to the sender queue
  function automatic void add_req(int unsigned r, int unsigned c,
                                  logic [31:0] smp, int unsigned k);
    pending_reqs.insert(pending_reqs.size(), make_req(r, c, smp, 16'(k)));
  endfunction

  // Hold until the sender queue drains
  task automatic drain_requests();
    while (pending_reqs.size() != 0 || s_axis_tvalid) @(posedge clk_i);
  endtask

  initial begin
    int unsigned r, c, k, n;
    foreach (mean_mirror[i]) begin
      mean_mirror[i] = '0;
      sumsq_mirror[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, zero count, symmetry, sign of the difference, saturation
    add_req(0, 0, 32'h0, 1);
    add_req(31, 31, 32'hFFFF_FFFF, 0);
    add_req(31, 31, 32'h0, 2);
    add_req(31, 31, 32'hFFFF_FFFF, 3);
    add_req(31, 31, 32'h0, 16'hFFFF);
    add_req(3, 17, 32'h0001_0000, 1);
    add_req(17, 3, 32'h0005_8000, 2);
    add_req(3, 17, 32'h0000_0001, 3);
    add_req(0, 31, 32'hAAAA_5555, 16'hAAAA);
    add_req(31, 0, 32'h5555_AAAA, 16'h5555);
    // Push one element to saturation, then add again at the maximum
    for (int i = 0; i < 10; i++)
      add_req(5, 9, (i % 2) ? 32'hFFFF_FFFF : 32'h0, 2);

    // Random: mostly a small working set of elements, counts mostly from 1 to 40
    for (int p = 0; p < 4; p++) begin
      drain_requests();
      phase = phase_e'(p);
      for (int i = 0; i < 480; i++) begin
        n = $urandom_range(9);
        if (n < 7) begin
          r = $urandom_range(3); c = $urandom_range(3);
        end else begin
          r = $urandom_range(31); c = $urandom_range(31);
        end
        k = (n == 9) ? $urandom_range(16'hFFFF) : $urandom_range(1, 40);
        add_req(r, c, (n == 8) ? $urandom() : $urandom_range(32'h00FF_FFFF), k);
      end
    end
    drain_requests();
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (expected_updates.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (mismatches == 0 && expected_updates.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Timeout: sweep, 1940 requests with stalls and element hazards, many times over
  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

endmodule

/* filelist.f */
hdl/rmsm_pkg.sv
hdl/rmsm_ram.sv
hdl/rmsm_div_pipe.sv
hdl/running_mean_sumsq_matrix_unit.sv
dv/tb_top.sv
